// ===== rtl/core/cscspmv_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// CSC sparse matrix-vector product: shared types and constants
// Field widths, action and mode codes, register indexes, controller states
// and the structs that pass between the controller, datapath and top level.
// ============================================================================
package cscspmv_pkg;

  localparam int MAX_DIM_DEFAULT = 1024;

  localparam int IDX_W     = 10;
  localparam int OPERAND_W = 32;
  localparam int SUM_W     = 48;
  localparam int PROD_W    = 64;
  localparam int FRAC_W    = 16;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int MODE_W    = 2;

  localparam logic [SUM_W-1:0] ACC_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [SUM_W-1:0] ACC_MIN = 48'h8000_0000_0000;

  localparam logic [CFG_W-1:0] DIM_RESET = 11'd1024;

  localparam logic [MODE_W-1:0] MODE_PLAIN     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TRANSPOSE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SYMMETRIC = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PRODUCT_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS     = 2'd2;

  typedef enum logic [1:0] {
    ACT_LOAD,
    ACT_NONZERO,
    ACT_READ,
    ACT_CLEAR
  } action_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    action_t                      action;
    logic [IDX_W-1:0]             entry_index;
    logic [IDX_W-1:0]             row_index;
    logic [IDX_W-1:0]             col_index;
    logic signed [OPERAND_W-1:0]  operand;
  } item_t;

  typedef struct packed {
    logic [MODE_W-1:0] product_mode;
    logic [CFG_W-1:0]  num_rows;
    logic [CFG_W-1:0]  num_cols;
  } cfg_t;

  typedef struct packed {
    logic mul_en;
  } mac_ctl_t;

  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum_out;
    logic             status;
  } res_t;

endpackage

// ===== rtl/core/cscspmv_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Generic synchronous RAM
// One write port and one read port, read data registered in the next cycle.
// ============================================================================
module cscspmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/cscspmv_mac.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Multiply and saturating accumulate datapath
// Registers the Q16.16 product, scales it to Q32.16 by flooring and adds it
// to an accumulator value with clamping at the 48-bit signed limits.
// ============================================================================
module cscspmv_mac (
  input  logic                                     clk,
  input  cscspmv_pkg::mac_ctl_t                    ctl,
  input  logic signed [cscspmv_pkg::OPERAND_W-1:0] operand,
  input  logic [cscspmv_pkg::OPERAND_W-1:0]        vec_data,
  input  logic [cscspmv_pkg::SUM_W-1:0]            acc_data,
  output logic [cscspmv_pkg::SUM_W-1:0]            sum
);
  import cscspmv_pkg::*;

  logic signed [PROD_W-1:0] product;
  logic [SUM_W-1:0]         scaled;
  logic [SUM_W:0]           sum_wide;
  logic                     overflow;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      product <= operand * $signed(vec_data);
    end
  end

  // An arithmetic shift right floors, which is the required rounding.
  assign scaled   = product[PROD_W-1:FRAC_W];
  assign sum_wide = {acc_data[SUM_W-1], acc_data} + {scaled[SUM_W-1], scaled};
  assign overflow = sum_wide[SUM_W] ^ sum_wide[SUM_W-1];

  always_comb begin
    if (overflow) begin
      sum = sum_wide[SUM_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sum = sum_wide[SUM_W-1:0];
    end
  end

endmodule

// ===== rtl/core/cscspmv_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Sequencer for the sparse matrix-vector product
// Checks indexes against the active limits, loads the vector memory, drives
// accumulator read-modify-write steps and sweeps the accumulators to zero.
// ============================================================================
module cscspmv_ctrl #(
  parameter int MAX_DIM = cscspmv_pkg::MAX_DIM_DEFAULT,
  localparam int AW = $clog2(MAX_DIM)
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  input  cscspmv_pkg::item_t                       item,
  input  cscspmv_pkg::cfg_t                        cfg,
  input  logic                                     out_free,
  output logic                                     vec_we,
  output logic [AW-1:0]                            vec_waddr,
  output logic [cscspmv_pkg::OPERAND_W-1:0]        vec_wdata,
  output logic [AW-1:0]                            vec_raddr,
  output logic                                     acc_we,
  output logic [AW-1:0]                            acc_waddr,
  output logic [cscspmv_pkg::SUM_W-1:0]            acc_wdata,
  output logic [AW-1:0]                            acc_raddr,
  input  logic [cscspmv_pkg::SUM_W-1:0]            acc_rdata,
  input  logic [cscspmv_pkg::SUM_W-1:0]            mac_sum,
  output cscspmv_pkg::mac_ctl_t                    mac_ctl,
  output logic signed [cscspmv_pkg::OPERAND_W-1:0] mul_operand,
  output cscspmv_pkg::res_t                        res
);
  import cscspmv_pkg::*;

  localparam int LIM_W = ($clog2(MAX_DIM + 1) > CFG_W) ? $clog2(MAX_DIM + 1) : CFG_W;
  localparam logic [LIM_W-1:0] DIM_CAP = LIM_W'(MAX_DIM);
  localparam logic [AW-1:0] SWEEP_LAST = AW'(MAX_DIM - 1);

  function automatic logic [LIM_W-1:0] eff_limit(input logic [CFG_W-1:0] r);
    logic [LIM_W-1:0] w;
    w = LIM_W'(r);
    return (w > DIM_CAP) ? DIM_CAP : w;
  endfunction

  state_t state, state_next;

  logic [AW-1:0]    sweep_cnt;
  logic             sweep_reply;
  logic             second_pending;
  logic [AW-1:0]    tgt;
  logic [AW-1:0]    second_vec;
  logic [AW-1:0]    second_tgt;
  logic [SUM_W-1:0] res_sum;
  logic             res_status;

  logic [LIM_W-1:0] rows, cols, vec_len, res_len;
  logic [LIM_W-1:0] entry_w, row_w, col_w;
  logic             entry_vec_ok, entry_res_ok, nz_ok, item_ok;
  logic [AW-1:0]    first_vec, first_tgt;
  logic             accept, sweep_last;

  assign rows    = eff_limit(cfg.num_rows);
  assign cols    = eff_limit(cfg.num_cols);
  assign entry_w = LIM_W'(item.entry_index);
  assign row_w   = LIM_W'(item.row_index);
  assign col_w   = LIM_W'(item.col_index);

  always_comb begin
    unique case (cfg.product_mode)
      MODE_TRANSPOSE: begin
        vec_len = rows;
        res_len = cols;
        nz_ok   = (row_w < rows) && (col_w < cols);
      end
      MODE_SYMMETRIC: begin
        vec_len = cols;
        res_len = cols;
        nz_ok   = (row_w < cols) && (col_w < cols);
      end
      MODE_PLAIN: begin
        vec_len = cols;
        res_len = rows;
        nz_ok   = (row_w < rows) && (col_w < cols);
      end
      default: begin
        vec_len = cols;
        res_len = rows;
        nz_ok   = 1'b0;
      end
    endcase
  end

  assign entry_vec_ok = entry_w < vec_len;
  assign entry_res_ok = entry_w < res_len;

  always_comb begin
    unique case (item.action)
      ACT_LOAD:    item_ok = entry_vec_ok;
      ACT_NONZERO: item_ok = nz_ok;
      ACT_READ:    item_ok = entry_res_ok;
      ACT_CLEAR:   item_ok = 1'b1;
      default:     item_ok = 1'b0;
    endcase
  end

  assign first_vec  = (cfg.product_mode == MODE_TRANSPOSE) ? AW'(item.row_index)
                                                           : AW'(item.col_index);
  assign first_tgt  = (cfg.product_mode == MODE_TRANSPOSE) ? AW'(item.col_index)
                                                           : AW'(item.row_index);
  assign accept     = s_tvalid && s_tready;
  assign sweep_last = sweep_cnt == SWEEP_LAST;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    s_tready       = 1'b0;
    vec_we         = 1'b0;
    vec_waddr      = AW'(item.entry_index);
    vec_wdata      = item.operand;
    vec_raddr      = first_vec;
    acc_we         = 1'b0;
    acc_waddr      = tgt;
    acc_wdata      = mac_sum;
    acc_raddr      = tgt;
    mac_ctl.mul_en = 1'b0;
    res.valid      = 1'b0;
    res.sum_out    = res_sum;
    res.status     = res_status;
    unique case (state)
      ST_SWEEP: begin
        acc_we    = 1'b1;
        acc_waddr = sweep_cnt;
        acc_wdata = '0;
        if (sweep_last) begin
          state_next = sweep_reply ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready  = 1'b1;
        acc_raddr = AW'(item.entry_index);
        if (s_tvalid) begin
          unique case (item.action)
            ACT_LOAD: begin
              vec_we     = entry_vec_ok;
              state_next = ST_DONE;
            end
            ACT_NONZERO: state_next = nz_ok ? ST_MUL : ST_DONE;
            ACT_READ:    state_next = entry_res_ok ? ST_READ : ST_DONE;
            ACT_CLEAR:   state_next = ST_SWEEP;
            default:     state_next = ST_DONE;
          endcase
        end
      end
      ST_MUL: begin
        mac_ctl.mul_en = 1'b1;
        state_next     = ST_ACC;
      end
      ST_ACC: begin
        acc_we     = 1'b1;
        vec_raddr  = second_vec;
        state_next = second_pending ? ST_MUL : ST_DONE;
      end
      ST_READ: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          res.valid  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt      <= '0;
      sweep_reply    <= 1'b0;
      second_pending <= 1'b0;
    end else begin
      if (state == ST_SWEEP) begin
        sweep_cnt <= sweep_last ? '0 : sweep_cnt + 1'b1;
      end
      if (accept) begin
        sweep_reply    <= item.action == ACT_CLEAR;
        second_pending <= (item.action == ACT_NONZERO) && nz_ok &&
                          (cfg.product_mode == MODE_SYMMETRIC) &&
                          (item.row_index != item.col_index);
      end
      if (state == ST_ACC) begin
        second_pending <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mul_operand <= item.operand;
      tgt         <= first_tgt;
      second_vec  <= AW'(item.row_index);
      second_tgt  <= AW'(item.col_index);
      res_sum     <= '0;
      res_status  <= !item_ok;
    end
    if (state == ST_ACC) begin
      tgt <= second_tgt;
    end
    if (state == ST_READ) begin
      res_sum <= acc_rdata;
    end
  end

  a_mul_then_acc: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL |=> state == ST_ACC)
    else $error("multiply step not followed by accumulate step");

  a_second_pass: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACC && second_pending) |=> (state == ST_MUL && !second_pending))
    else $error("mirrored update of a symmetric nonzero was lost");

  a_single_writer: assert property (@(posedge clk) disable iff (rst)
    !(vec_we && acc_we))
    else $error("vector load overlaps an accumulator write");

  a_clear_sweep: assert property (@(posedge clk) disable iff (rst)
    (accept && item.action == ACT_CLEAR) |=> (state == ST_SWEEP && sweep_cnt == '0))
    else $error("clear does not start a full sweep");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !out_free) |=>
      (state == ST_DONE && $stable(res_sum) && $stable(res_status)))
    else $error("pending result changed while output was full");

endmodule

// ===== rtl/core/csc_sparse_matrix_vector_multiply.sv =====
`timescale 1ns / 1ps
// ============================================================================
// CSC sparse matrix-vector product engine
// Plain, transpose and symmetric products over a column-ordered nonzero
// stream, with Q16.16 operands and 48-bit saturating Q32.16 accumulators.
// ============================================================================
//
// Channel  Direction  Transfer when          Payload
// s_*      in         s_tvalid & s_tready    s_tuser: action; s_tdata: indexes, operand
// m_*      out        m_tvalid & m_tready    m_tuser: status; m_tdata: sum_out
// cfg_*    in         cfg_valid & cfg_ready  cfg_index, cfg_data
//
// Loads write the vector on acceptance, reads pass a read step, nonzeros the registered
// multiply and accumulator read-modify-write, twice if symmetric and off the diagonal.
// A clear sweeps all MAX_DIM accumulator entries, one per cycle, then answers.
// After reset the same sweep runs before s_tready rises.
// A stalled output holds the sequencer after the result is ready.
module csc_sparse_matrix_vector_multiply #(
  parameter int MAX_DIM = cscspmv_pkg::MAX_DIM_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // entry_index, row_index, col_index, operand, zero pad
  input  logic [1:0]  s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // sum_out
  output logic        m_tuser,   // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);
  import cscspmv_pkg::*;

  localparam int AW = $clog2(MAX_DIM);

  item_t            item;
  cfg_t             cfg;
  mac_ctl_t         mac_ctl;
  res_t             res;
  logic             out_free;
  logic             vec_we, acc_we;
  logic [AW-1:0]    vec_waddr, vec_raddr, acc_waddr, acc_raddr;
  logic [OPERAND_W-1:0] vec_wdata, vec_rdata;
  logic [SUM_W-1:0] acc_wdata, acc_rdata, mac_sum;
  logic signed [OPERAND_W-1:0] mul_operand;

  assign item.action      = action_t'(s_tuser);
  assign item.entry_index = s_tdata[9:0];
  assign item.row_index   = s_tdata[19:10];
  assign item.col_index   = s_tdata[29:20];
  assign item.operand     = s_tdata[61:30];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.product_mode <= MODE_PLAIN;
      cfg.num_rows     <= DIM_RESET;
      cfg.num_cols     <= DIM_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PRODUCT_MODE: cfg.product_mode <= cfg_data[MODE_W-1:0];
        REG_NUM_ROWS:     cfg.num_rows     <= cfg_data;
        REG_NUM_COLS:     cfg.num_cols     <= cfg_data;
        default: ;
      endcase
    end
  end

  cscspmv_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .item        (item),
    .cfg         (cfg),
    .out_free    (out_free),
    .vec_we      (vec_we),
    .vec_waddr   (vec_waddr),
    .vec_wdata   (vec_wdata),
    .vec_raddr   (vec_raddr),
    .acc_we      (acc_we),
    .acc_waddr   (acc_waddr),
    .acc_wdata   (acc_wdata),
    .acc_raddr   (acc_raddr),
    .acc_rdata   (acc_rdata),
    .mac_sum     (mac_sum),
    .mac_ctl     (mac_ctl),
    .mul_operand (mul_operand),
    .res         (res)
  );

  cscspmv_ram #(
    .WIDTH (OPERAND_W),
    .DEPTH (MAX_DIM)
  ) u_vector_ram (
    .clk   (clk),
    .we    (vec_we),
    .waddr (vec_waddr),
    .wdata (vec_wdata),
    .raddr (vec_raddr),
    .rdata (vec_rdata)
  );

  cscspmv_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_DIM)
  ) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  cscspmv_mac u_mac (
    .clk      (clk),
    .ctl      (mac_ctl),
    .operand  (mul_operand),
    .vec_data (vec_rdata),
    .acc_data (acc_rdata),
    .sum      (mac_sum)
  );

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      m_tdata <= res.sum_out;
      m_tuser <= res.status;
    end
  end

endmodule

// ===== sim/csc_sparse_matrix_vector_multiply_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Testbench for the CSC sparse matrix-vector product engine
// Drives loads, nonzeros, reads and clears over the input stream and checks
// every result against a scoreboard that keeps its own vector store,
// saturating accumulators and register copy. A directed part covers the
// numeric and index corner cases, then random phases run under random idling
// on both sides, including one long output stall, across all product modes.
// ============================================================================
module csc_sparse_matrix_vector_multiply_tb;
  import cscspmv_pkg::*;

  localparam int DIM = MAX_DIM_DEFAULT;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam longint SUM_HI = 64'sd140737488355327;
  localparam longint SUM_LO = -SUM_HI - 64'sd1;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             status;
  } spmv_result_t;

  class spmv_scoreboard;
    logic [MODE_W-1:0]           mode;
    logic [CFG_W-1:0]            nrows;
    logic [CFG_W-1:0]            ncols;
    logic signed [OPERAND_W-1:0] vec [DIM];
    bit                          loaded [DIM];
    int                          loaded_list[$];
    logic signed [SUM_W-1:0]     acc [DIM];
    spmv_result_t                pending_results[$];
    int                          failures;

    function new();
      mode = MODE_PLAIN;
      nrows = DIM_RESET;
      ncols = DIM_RESET;
      failures = 0;
      foreach (acc[i]) begin
        acc[i] = '0;
        vec[i] = '0;
        loaded[i] = 1'b0;
      end
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_PRODUCT_MODE: mode = val[MODE_W-1:0];
        REG_NUM_ROWS:     nrows = val;
        REG_NUM_COLS:     ncols = val;
        default: ;
      endcase
    endfunction

    function int rows_lim();
      return (int'(nrows) > DIM) ? DIM : int'(nrows);
    endfunction

    function int cols_lim();
      return (int'(ncols) > DIM) ? DIM : int'(ncols);
    endfunction

    function int vec_len();
      return (mode == MODE_TRANSPOSE) ? rows_lim() : cols_lim();
    endfunction

    function int res_len();
      return (mode == MODE_TRANSPOSE || mode == MODE_SYMMETRIC) ? cols_lim() : rows_lim();
    endfunction

    function bit nz_in_range(item_t it);
      int r;
      int c;
      r = int'(it.row_index);
      c = int'(it.col_index);
      if (mode == MODE_PLAIN || mode == MODE_TRANSPOSE)
        return (r < rows_lim()) && (c < cols_lim());
      if (mode == MODE_SYMMETRIC)
        return (r < cols_lim()) && (c < cols_lim());
      return 1'b0;
    endfunction

    // True when a nonzero would use a vector entry that was never loaded.
    function bit reads_unloaded(item_t it);
      if (it.action != ACT_NONZERO || !nz_in_range(it))
        return 1'b0;
      if (mode == MODE_TRANSPOSE)
        return !loaded[it.row_index];
      return !loaded[it.col_index] || (mode == MODE_SYMMETRIC && !loaded[it.row_index]);
    endfunction

    // Q16.16 times Q16.16, floored to Q32.16, added with saturation.
    function void accumulate(int idx, logic signed [OPERAND_W-1:0] x,
                             logic signed [OPERAND_W-1:0] v);
      longint p;
      longint s;
      p = longint'(x) * longint'(v);
      s = longint'(acc[idx]) + (p >>> FRAC_W);
      if (s > SUM_HI)
        s = SUM_HI;
      if (s < SUM_LO)
        s = SUM_LO;
      acc[idx] = s[SUM_W-1:0];
    endfunction

    function void note_input(item_t it);
      spmv_result_t res;
      int e;
      res = '0;
      e = int'(it.entry_index);
      case (it.action)
        ACT_LOAD: begin
          if (e < vec_len()) begin
            vec[e] = it.operand;
            if (!loaded[e]) begin
              loaded[e] = 1'b1;
              loaded_list.push_back(e);
            end
          end else begin
            res.status = 1'b1;
          end
        end
        ACT_NONZERO: begin
          if (!nz_in_range(it)) begin
            res.status = 1'b1;
          end else if (mode == MODE_TRANSPOSE) begin
            accumulate(int'(it.col_index), it.operand, vec[it.row_index]);
          end else begin
            accumulate(int'(it.row_index), it.operand, vec[it.col_index]);
            if (mode == MODE_SYMMETRIC && it.row_index != it.col_index)
              accumulate(int'(it.col_index), it.operand, vec[it.row_index]);
          end
        end
        ACT_READ: begin
          if (e < res_len())
            res.sum = acc[e];
          else
            res.status = 1'b1;
        end
        default: begin
          foreach (acc[i])
            acc[i] = '0;
        end
      endcase
      pending_results.push_back(res);
    endfunction

    function void check_output(logic [SUM_W-1:0] sum, logic status);
      spmv_result_t want;
      if (pending_results.size() == 0) begin
        $error("result transfer with no result pending: sum_out %h status %0d", sum, status);
        failures++;
        return;
      end
      want = pending_results.pop_front();
      if (want.sum !== sum) begin
        $error("sum_out: expected %h, actual %h", want.sum, sum);
        failures++;
      end
      if (want.status !== status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        failures++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;

  spmv_scoreboard sb = new();
  int  sent = 0;
  logic hold_req = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_left = 0;
  int  out_cycle = 0;

  csc_sparse_matrix_vector_multiply dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_output(m_tdata, m_tuser);
    out_cycle++;
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 400;
      m_tready <= 1'b0;
    end else if (out_cycle >= 8000 && out_cycle < 11000) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 33);
    end
  end

  function automatic logic [OPERAND_W-1:0] rand_operand();
    int r;
    r = $urandom_range(99);
    if (r < 25)
      return OPERAND_W'($signed($urandom_range(524288)) - 262144);
    if (r < 50)
      return OPERAND_W'($urandom());
    if (r < 65) begin
      case ($urandom_range(5))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        3: return 32'h0000_0001;
        4: return 32'hFFFF_FFFF;
        default: return 32'h0001_0000;
      endcase
    end
    return OPERAND_W'($signed($urandom_range(33554432)) - 16777216);
  endfunction

  function automatic item_t rand_item(action_t a);
    item_t it;
    it.action = a;
    it.entry_index = IDX_W'($urandom());
    it.row_index = IDX_W'($urandom());
    it.col_index = IDX_W'($urandom());
    it.operand = rand_operand();
    return it;
  endfunction

  function automatic int pick_loaded(int limit);
    int cand;
    if (sb.loaded_list.size() == 0)
      return -1;
    repeat (40) begin
      cand = sb.loaded_list[$urandom_range(sb.loaded_list.size() - 1)];
      if (cand < limit)
        return cand;
    end
    return -1;
  endfunction

  task automatic send_item(item_t it);
    item_t x;
    x = it;
    // A nonzero that would touch an unloaded vector entry becomes a read.
    if (sb.reads_unloaded(x))
      x.action = ACT_READ;
    if (!(sent >= 400 && sent < 600)) begin
      while ($urandom_range(99) < 33) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser <= x.action;
    s_tdata <= {2'b00, x.operand, x.col_index, x.row_index, x.entry_index};
    do @(posedge clk); while (!s_tready);
    sb.note_input(x);
    sent++;
  endtask

  task automatic put(action_t a, int e, int r, int c, logic [OPERAND_W-1:0] op);
    item_t it;
    it.action = a;
    it.entry_index = IDX_W'(e);
    it.row_index = IDX_W'(r);
    it.col_index = IDX_W'(c);
    it.operand = op;
    send_item(it);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  task automatic set_config(logic [MODE_W-1:0] mode, logic [CFG_W-1:0] nr,
                            logic [CFG_W-1:0] nc);
    wait_idle();
    write_reg(REG_PRODUCT_MODE, CFG_W'(mode));
    write_reg(REG_NUM_ROWS, nr);
    write_reg(REG_NUM_COLS, nc);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] rand_dim();
    int r;
    r = $urandom_range(99);
    if (r < 70)
      return CFG_W'($urandom_range(16, 1));
    if (r < 80)
      return CFG_W'($urandom_range(200, 17));
    if (r < 88)
      return CFG_W'(1024);
    if (r < 93)
      return CFG_W'(1);
    if (r < 97)
      return CFG_W'($urandom_range(2047, 1025));
    return CFG_W'(0);
  endfunction

  task automatic run_phase(int p);
    logic [MODE_W-1:0] mode;
    logic [CFG_W-1:0]  nr;
    logic [CFG_W-1:0]  nc;
    item_t             it;
    int                rows;
    int                cols;
    int                vlen;
    int                rlen;
    int                r;
    int                c;
    int                pick;
    case (p)
      0: begin mode = MODE_SYMMETRIC; nr = 11'd1024; nc = 11'd1024; end
      1: begin mode = MODE_PLAIN;     nr = 11'd1;    nc = 11'd1;    end
      2: begin mode = MODE_TRANSPOSE; nr = 11'd1024; nc = 11'd1;    end
      3: begin mode = MODE_PLAIN;     nr = 11'd1;    nc = 11'd1024; end
      default: begin
        pick = $urandom_range(99);
        mode = (pick < 30) ? MODE_PLAIN : (pick < 60) ? MODE_TRANSPOSE :
               (pick < 95) ? MODE_SYMMETRIC : MODE_UNUSED;
        nr = rand_dim();
        nc = rand_dim();
      end
    endcase
    set_config(mode, nr, nc);
    rows = sb.rows_lim();
    cols = sb.cols_lim();
    vlen = sb.vec_len();
    rlen = sb.res_len();

    send_item(rand_item(ACT_CLEAR));
    if (vlen <= 64) begin
      for (int i = 0; i < vlen; i++) begin
        it = rand_item(ACT_LOAD);
        it.entry_index = IDX_W'(i);
        send_item(it);
      end
    end else if (vlen > 0) begin
      repeat (24) begin
        it = rand_item(ACT_LOAD);
        it.entry_index = IDX_W'($urandom_range(vlen - 1));
        send_item(it);
      end
    end

    if (p == 0)
      hold_req <= 1'b1;

    repeat ($urandom_range(70, 30)) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        it = rand_item(ACT_NONZERO);
        case (mode)
          MODE_PLAIN: begin
            if (rows > 0)
              it.row_index = IDX_W'($urandom_range(rows - 1));
            c = pick_loaded(cols);
            if (c >= 0)
              it.col_index = IDX_W'(c);
          end
          MODE_TRANSPOSE: begin
            if (cols > 0)
              it.col_index = IDX_W'($urandom_range(cols - 1));
            r = pick_loaded(rows);
            if (r >= 0)
              it.row_index = IDX_W'(r);
          end
          MODE_SYMMETRIC: begin
            r = pick_loaded(cols);
            c = pick_loaded(cols);
            if (r >= 0)
              it.row_index = IDX_W'(r);
            if (c >= 0)
              it.col_index = IDX_W'(c);
            if ($urandom_range(4) == 0)
              it.col_index = it.row_index;
          end
          default: ;
        endcase
      end else if (pick < 80 && rlen > 0) begin
        it = rand_item(ACT_READ);
        it.entry_index = IDX_W'($urandom_range(rlen - 1));
      end else begin
        it = rand_item(action_t'(2'($urandom_range(3))));
        if (it.action == ACT_CLEAR && $urandom_range(3) != 0)
          it.action = ACT_READ;
      end
      send_item(it);
    end

    if (rlen <= 32) begin
      for (int i = 0; i < rlen; i++) begin
        it = rand_item(ACT_READ);
        it.entry_index = IDX_W'(i);
        send_item(it);
      end
    end else begin
      repeat (16) begin
        it = rand_item(ACT_READ);
        it.entry_index = IDX_W'($urandom_range(rlen - 1));
        send_item(it);
      end
    end
  endtask

  initial begin
    int p;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: plain product, full dimensions.
    put(ACT_LOAD, 0, 0, 0, 32'h7FFF_FFFF);
    put(ACT_LOAD, 1023, 0, 0, 32'h8000_0000);
    put(ACT_LOAD, 1, 0, 0, 32'hFFFF_FFFF);
    put(ACT_LOAD, 2, 0, 0, 32'h0001_0000);
    put(ACT_NONZERO, 0, 0, 0, 32'h7FFF_FFFF);
    put(ACT_NONZERO, 0, 0, 0, 32'h7FFF_FFFF);
    put(ACT_READ, 0, 0, 0, 32'h0);
    put(ACT_NONZERO, 0, 2, 1, 32'h0000_0001);
    put(ACT_READ, 2, 0, 0, 32'h0);
    put(ACT_NONZERO, 0, 1023, 1023, 32'h7FFF_FFFF);
    put(ACT_NONZERO, 0, 1023, 1023, 32'h7FFF_FFFF);
    put(ACT_NONZERO, 0, 1023, 1023, 32'h7FFF_FFFF);
    put(ACT_READ, 1023, 0, 0, 32'h0);
    put(ACT_CLEAR, 0, 0, 0, 32'h0);
    put(ACT_READ, 0, 0, 0, 32'h0);

    // Undefined mode with an oversized row count and a zero column count.
    set_config(MODE_UNUSED, 11'd2047, 11'd0);
    put(ACT_LOAD, 0, 0, 0, 32'h1234_5678);
    put(ACT_READ, 1023, 0, 0, 32'h0);
    put(ACT_NONZERO, 0, 0, 0, 32'h0001_0000);

    // Symmetric: an entry below the diagonal, then indexes past the size.
    set_config(MODE_SYMMETRIC, 11'd3, 11'd3);
    put(ACT_NONZERO, 0, 2, 0, 32'h0001_0000);
    put(ACT_READ, 0, 0, 0, 32'h0);
    put(ACT_LOAD, 3, 0, 0, 32'h0000_0005);
    put(ACT_NONZERO, 0, 3, 0, 32'h0001_0000);

    set_config(MODE_TRANSPOSE, 11'd2, 11'd5);
    put(ACT_LOAD, 2, 0, 0, 32'h0000_0007);
    put(ACT_NONZERO, 0, 1, 4, 32'h8000_0000);
    put(ACT_READ, 4, 0, 0, 32'h0);

    p = 0;
    while (sent < 1010) begin
      run_phase(p);
      p++;
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.failures == 0 && sb.pending_results.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/cscspmv_pkg.sv
rtl/core/cscspmv_ram.sv
rtl/core/cscspmv_mac.sv
rtl/core/cscspmv_ctrl.sv
rtl/core/csc_sparse_matrix_vector_multiply.sv
sim/csc_sparse_matrix_vector_multiply_tb.sv
